[design/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ept: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ept: next-cycle check failed");

`endif

[design/ept_pkg.sv]
// Types, constants and action codes of the entity proximity query table.
package ept_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int RESULT_LIMIT    = 32;
    localparam int NW              = $clog2(RESULT_LIMIT + 1);
    localparam int ID_W            = 16;
    localparam int POS_W           = 16;
    localparam int NEXT_ID_W       = 17;
    localparam int SQ_W            = 32;
    localparam int DIST_W          = 34;

    localparam logic [NEXT_ID_W-1:0] ID_LIMIT = 17'd65535;
    localparam logic [NEXT_ID_W-1:0] ID_FIRST = 17'd1;

    // Action codes
    localparam logic [2:0] ACT_SPAWN   = 3'd0;
    localparam logic [2:0] ACT_DESTROY = 3'd1;
    localparam logic [2:0] ACT_RANGE   = 3'd2;
    localparam logic [2:0] ACT_NEAREST = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    typedef struct packed {
        logic [2:0]              action;
        logic [ID_W-1:0]         target_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [POS_W-1:0]        query_range;
    } t_in_req;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        logic            hit;
        logic            last;
    } t_out_rsp;

    // One table entry as stored in the memory
    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_entry;

    // Result of the distance unit for one entry
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dsq;
    } t_dist_res;

endpackage

[design/ept_dist.sv]
// Shared squared-distance unit: three-stage pipeline, one entry per enabled cycle.
module ept_dist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  ept_pkg::t_entry                 i_entry,
    input  logic signed [ept_pkg::POS_W-1:0] i_cx,
    input  logic signed [ept_pkg::POS_W-1:0] i_cy,
    input  logic signed [ept_pkg::POS_W-1:0] i_cz,
    output ept_pkg::t_dist_res              o_res,
    output logic                            o_busy
);
    import ept_pkg::*;

    // |a - b| always fits in 16 bits unsigned
    function automatic logic [POS_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                  input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic [POS_W:0]        neg;
        d   = {a[POS_W-1], a} - {b[POS_W-1], b};
        neg = -d;
        return d[POS_W] ? neg[POS_W-1:0] : d[POS_W-1:0];
    endfunction

    logic              r_v1, r_v2, r_v3;
    logic [ID_W-1:0]   r_id1, r_id2, r_id3;
    logic [POS_W-1:0]  r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]   r_sx, r_sy, r_sz;
    logic [DIST_W-1:0] r_sum;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Differences, squares, sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_id1 <= i_entry.id;
            r_dx  <= abs_diff(i_entry.x, i_cx);
            r_dy  <= abs_diff(i_entry.y, i_cy);
            r_dz  <= abs_diff(i_entry.z, i_cz);
            r_id2 <= r_id1;
            r_sx  <= {{(SQ_W-POS_W){1'b0}}, r_dx} * {{(SQ_W-POS_W){1'b0}}, r_dx};
            r_sy  <= {{(SQ_W-POS_W){1'b0}}, r_dy} * {{(SQ_W-POS_W){1'b0}}, r_dy};
            r_sz  <= {{(SQ_W-POS_W){1'b0}}, r_dz} * {{(SQ_W-POS_W){1'b0}}, r_dz};
            r_id3 <= r_id2;
            r_sum <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
        end
    end

    assign o_res.valid = r_v3;
    assign o_res.id    = r_id3;
    assign o_res.dsq   = r_sum;
    assign o_busy      = r_v1 | r_v2 | r_v3;

endmodule

[design/entity_proximity_query_table.sv]
// Entity proximity query table: insertion-ordered entity store with 3D proximity search.
//
// Input channel i_in (valid/ready) carries one request: spawn, destroy, range query,
// nearest query or clear. Output channel o_out (valid/ready) carries results; each
// request gives one result, except a range query with hits, which gives one per hit
// (at most 32) with last set on the final one.
// Spawn, clear and unknown actions pass through ST_SINGLE, which loads their result
// into the output register. Destroy walks the table through the single memory read
// port, one entry per cycle while the output register is free, and loads its result
// once the walk ends. Queries also pass every entry through the shared distance
// pipeline (read, diff, square, sum), one entry per cycle while not stalled; their
// final result loads once the pipeline drains. o_in_ready is high only between
// requests, so a new request is accepted only once the last one's final result is loaded.
// A stalled receiver freezes the memory read and the distance pipeline until the
// output register frees; a new request may be accepted while the last result waits.
// Reset (synchronous, active low) empties the table and restarts ids at 1; table
// contents need no clearing, only entries below the fill count are ever used.
module entity_proximity_query_table #(
    parameter int TABLE_DEPTH = ept_pkg::TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ept_pkg::t_in_req i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ept_pkg::t_out_rsp o_out
);
    import ept_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;

    logic [1:0]           r_state;
    logic [CW-1:0]        r_count;
    logic [NEXT_ID_W-1:0] r_next_id;
    logic [CW-1:0]        r_iss;
    logic [CW-1:0]        r_w;
    logic [NW-1:0]        r_n;
    logic                 r_v1;
    logic                 r_pend_v;
    logic                 r_found;
    logic                 r_removed;
    logic                 r_out_valid;

    t_in_req              r_req;
    logic [SQ_W-1:0]      r_r2;
    logic [DIST_W-1:0]    r_best;
    logic [ID_W-1:0]      r_best_id;
    logic [ID_W-1:0]      r_pend_id;
    t_entry               r_rd;
    t_out_rsp             r_out;

    t_entry               r_mem [0:(1<<AW)-1];

    logic                 en, accept, scan_more, scan_done, spawn_ok;
    logic                 range_hit, near_better, del_match, del_keep;
    logic                 we, out_load;
    logic [AW-1:0]        waddr;
    t_entry               wdata;
    t_out_rsp             out_data;
    t_dist_res            dres;
    logic                 d_busy;
    logic [DIST_W-1:0]    r2_ext;

    // Handshake and walk control
    assign en        = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept    = i_in_valid && o_in_ready;
    assign scan_more = (r_iss < r_count);
    assign scan_done = (r_state == ST_SCAN) && !scan_more && !r_v1 && !d_busy;
    assign spawn_ok  = (r_count < CW'(TABLE_DEPTH)) && (r_next_id <= ID_LIMIT)
                       && (r_next_id != '0);
    assign r2_ext    = DIST_W'(r_r2);

    // Per-entry decisions
    assign range_hit   = dres.valid && (r_req.action == ACT_RANGE)
                         && (dres.dsq <= r2_ext) && (r_n < NW'(RESULT_LIMIT));
    assign near_better = dres.valid && (r_req.action == ACT_NEAREST)
                         && (r_found ? (dres.dsq < r_best) : (dres.dsq < r2_ext));
    assign del_match   = r_v1 && (r_req.action == ACT_DESTROY) && (r_rd.id == r_req.target_id);
    assign del_keep    = r_v1 && (r_req.action == ACT_DESTROY) && (r_rd.id != r_req.target_id);

    // Memory write port: spawn append or destroy compaction
    always_comb begin
        we    = 1'b0;
        waddr = r_count[AW-1:0];
        wdata = r_rd;
        if ((r_state == ST_SINGLE) && en && (r_req.action == ACT_SPAWN) && spawn_ok) begin
            we       = 1'b1;
            wdata.id = r_next_id[ID_W-1:0];
            wdata.x  = r_req.pos_x;
            wdata.y  = r_req.pos_y;
            wdata.z  = r_req.pos_z;
        end else if (en && del_keep) begin
            we    = 1'b1;
            waddr = r_w[AW-1:0];
        end
    end

    // Table memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (en) begin
            r_rd <= r_mem[r_iss[AW-1:0]];
        end
    end

    ept_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1 && ((r_req.action == ACT_RANGE) || (r_req.action == ACT_NEAREST))),
        .i_entry (r_rd),
        .i_cx    (r_req.pos_x),
        .i_cy    (r_req.pos_y),
        .i_cz    (r_req.pos_z),
        .o_res   (dres),
        .o_busy  (d_busy)
    );

    // Result selection
    always_comb begin
        out_load           = 1'b0;
        out_data.result_id = '0;
        out_data.hit       = 1'b0;
        out_data.last      = 1'b1;
        if ((r_state == ST_SINGLE) && en) begin
            out_load = 1'b1;
            if ((r_req.action == ACT_SPAWN) && spawn_ok) begin
                out_data.result_id = r_next_id[ID_W-1:0];
                out_data.hit       = 1'b1;
            end
        end else if ((r_state == ST_SCAN) && en) begin
            if (scan_done) begin
                out_load = 1'b1;
                unique case (r_req.action)
                    ACT_DESTROY: begin
                        out_data.result_id = r_req.target_id;
                        out_data.hit       = r_removed;
                    end
                    ACT_NEAREST: begin
                        out_data.result_id = r_found ? r_best_id : '0;
                        out_data.hit       = r_found;
                    end
                    default: begin
                        out_data.result_id = r_pend_v ? r_pend_id : '0;
                        out_data.hit       = r_pend_v;
                    end
                endcase
            end else if (range_hit && r_pend_v) begin
                // a newer hit proves the held one is not the last
                out_load           = 1'b1;
                out_data.result_id = r_pend_id;
                out_data.hit       = 1'b1;
                out_data.last      = 1'b0;
            end
        end
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_next_id <= ID_FIRST;
            r_iss     <= '0;
            r_w       <= '0;
            r_n       <= '0;
            r_v1      <= 1'b0;
            r_pend_v  <= 1'b0;
            r_found   <= 1'b0;
            r_removed <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_iss     <= '0;
                        r_w       <= '0;
                        r_n       <= '0;
                        r_pend_v  <= 1'b0;
                        r_found   <= 1'b0;
                        r_removed <= 1'b0;
                        if ((i_in.action == ACT_DESTROY) || (i_in.action == ACT_RANGE)
                            || (i_in.action == ACT_NEAREST)) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_SINGLE;
                        end
                    end
                end
                ST_SINGLE: begin
                    if (en) begin
                        if ((r_req.action == ACT_SPAWN) && spawn_ok) begin
                            r_count   <= r_count + 1'b1;
                            r_next_id <= r_next_id + 1'b1;
                        end else if (r_req.action == ACT_CLEAR) begin
                            r_count   <= '0;
                            r_next_id <= ID_FIRST;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (en) begin
                        r_v1 <= scan_more;
                        if (scan_more) begin
                            r_iss <= r_iss + 1'b1;
                        end
                        if (del_match) begin
                            r_removed <= 1'b1;
                        end
                        if (del_keep) begin
                            r_w <= r_w + 1'b1;
                        end
                        if (range_hit) begin
                            r_pend_v <= 1'b1;
                            r_n      <= r_n + 1'b1;
                        end
                        if (near_better) begin
                            r_found <= 1'b1;
                        end
                        if (scan_done) begin
                            r_state <= ST_IDLE;
                            if (r_req.action == ACT_DESTROY) begin
                                r_count <= r_w;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Request, range squared, pending hit id and running best
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in;
            r_r2  <= {{(SQ_W-POS_W){1'b0}}, i_in.query_range}
                     * {{(SQ_W-POS_W){1'b0}}, i_in.query_range};
        end
        if (en && (r_state == ST_SCAN)) begin
            if (range_hit) begin
                r_pend_id <= dres.id;
            end
            if (near_better) begin
                r_best    <= dres.dsq;
                r_best_id <= dres.id;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[design/ept_checker.sv]
// Port-level checker for the entity proximity query table, bound to the top level.
`include "assert_macros.svh"

module ept_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input ept_pkg::t_in_req  i_in,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input ept_pkg::t_out_rsp o_out
);

    // Stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // One request at a time: ready drops right after an accept
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // A miss is always the only, and so the final, result of its request
    `ASSERT_IMPLIES(a_miss_is_last, i_clk, i_rst_n, o_out_valid && !o_out.hit, o_out.last)

    // Every result ahead of the final one is a range hit with a real id
    `ASSERT_IMPLIES(a_partial_has_id, i_clk, i_rst_n, o_out_valid && !o_out.last,
                    o_out.hit && (o_out.result_id != 16'd0))

endmodule

bind entity_proximity_query_table ept_checker u_ept_checker (.*);
